/* hdl/integer_literal_scanner_defines.svh */
// Assertion macros used by the scanner core.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef INTEGER_LITERAL_SCANNER_DEFINES_SVH
`define INTEGER_LITERAL_SCANNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ils_pkg.sv */
package ils_pkg;

    // Default digit limits of the four literal forms.
    localparam int DEF_MAX_BIN_DIGITS = 256;
    localparam int DEF_MAX_OCT_DIGITS = 24;
    localparam int DEF_MAX_HEX_DIGITS = 20;
    localparam int DEF_MAX_DEC_DIGITS = 20;

    // Base codes reported with a result.
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;
    localparam logic [1:0] BASE_DEC = 2'd3;

    // Scan phases.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_SIGNED = 4'd1,
        PH_ZERO   = 4'd2,
        PH_ZERO_B = 4'd3,
        PH_ZERO_X = 4'd4,
        PH_BIN    = 4'd5,
        PH_OCT    = 4'd6,
        PH_HEX    = 4'd7,
        PH_DEC    = 4'd8
    } phase_t;

    // One input word: a text character or the end-of-text mark.
    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
    } char_t;

    // One result word.
    typedef struct packed {
        logic        matched;
        logic        negative;
        logic [1:0]  base_code;
        logic [63:0] magnitude;
        logic [8:0]  length;
    } res_t;

    // Input register to scan core: a character that steps the scanner this cycle.
    typedef struct packed {
        logic  fire;
        char_t word;
    } step_t;

    // Scan core to result register: a finished result to load.
    typedef struct packed {
        logic valid;
        res_t word;
    } emit_t;

endpackage

/* hdl/ils_in_stage.sv */
module ils_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            char_valid,
    output logic            char_stall,
    input  ils_pkg::char_t  char_word,
    input  logic            res_free,
    output ils_pkg::step_t  step
);

    logic           valid_reg;
    logic           valid_next;
    ils_pkg::char_t word_reg;
    logic           advance;
    logic           accept;

    // The held character steps the scanner when the result register has room.
    assign advance    = valid_reg && res_free;
    assign char_stall = valid_reg && !advance;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= char_word;
        end
    end

    assign step.fire = advance;
    assign step.word = word_reg;

endmodule

/* hdl/ils_core.sv */
`include "integer_literal_scanner_defines.svh"

module ils_core
#(
    parameter int MAX_BIN_DIGITS = ils_pkg::DEF_MAX_BIN_DIGITS,
    parameter int MAX_OCT_DIGITS = ils_pkg::DEF_MAX_OCT_DIGITS,
    parameter int MAX_HEX_DIGITS = ils_pkg::DEF_MAX_HEX_DIGITS,
    parameter int MAX_DEC_DIGITS = ils_pkg::DEF_MAX_DEC_DIGITS
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  ils_pkg::step_t step,
    output ils_pkg::emit_t emit
);

    localparam int MAX_BO  = (MAX_BIN_DIGITS > MAX_OCT_DIGITS) ? MAX_BIN_DIGITS
                                                               : MAX_OCT_DIGITS;
    localparam int MAX_HD  = (MAX_HEX_DIGITS > MAX_DEC_DIGITS) ? MAX_HEX_DIGITS
                                                               : MAX_DEC_DIGITS;
    localparam int CNT_MAX = (MAX_BO > MAX_HD) ? MAX_BO : MAX_HD;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [CNT_W-1:0] LIM_BIN = CNT_W'(MAX_BIN_DIGITS);
    localparam logic [CNT_W-1:0] LIM_OCT = CNT_W'(MAX_OCT_DIGITS);
    localparam logic [CNT_W-1:0] LIM_HEX = CNT_W'(MAX_HEX_DIGITS);
    localparam logic [CNT_W-1:0] LIM_DEC = CNT_W'(MAX_DEC_DIGITS);
    localparam logic [CNT_W-1:0] LIM_TOP = CNT_W'(CNT_MAX);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // Digit value with a flag that says whether the character is a digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t bin_digit(input logic [7:0] c);
        digit_t d;
        d.ok  = (c == CH_ZERO) || (c == CH_ONE);
        d.val = {3'b000, c[0]};
        return d;
    endfunction

    function automatic digit_t dec_digit(input logic [7:0] c);
        digit_t d;
        d.ok  = (c >= CH_ZERO) && (c <= CH_NINE);
        d.val = c[3:0];
        return d;
    endfunction

    function automatic digit_t hex_digit(input logic [7:0] c);
        digit_t     d;
        logic [7:0] off;
        off = 8'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            d.ok  = 1'b1;
            d.val = c[3:0];
        end
        else if ((c >= CH_LO_A) && (c <= CH_LO_F))
        begin
            off   = c - CH_LO_A + 8'd10;
            d.ok  = 1'b1;
            d.val = off[3:0];
        end
        else if ((c >= CH_UP_A) && (c <= CH_UP_F))
        begin
            off   = c - CH_UP_A + 8'd10;
            d.ok  = 1'b1;
            d.val = off[3:0];
        end
        else
        begin
            d.ok  = 1'b0;
            d.val = 4'd0;
        end
        return d;
    endfunction

    ils_pkg::phase_t  phase_reg, phase_next;
    logic [63:0]      acc_reg, acc_next;
    logic             minus_reg, minus_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [8:0]       consumed_reg, consumed_next;

    logic [7:0]       ch;
    logic             at_end;
    logic             is_stop;
    digit_t           bdig, ddig, hdig;

    logic             go_start;
    logic             run_active;
    digit_t           run_dig;
    logic [CNT_W-1:0] run_limit;
    logic [1:0]       run_base;
    logic [63:0]      acc_scaled;

    logic             done;
    logic             done_ok;
    logic [1:0]       done_base;

    assign ch      = step.word.ch;
    assign at_end  = step.word.at_end;
    assign is_stop = (ch == CH_DOT) || (ch == CH_LO_E) || (ch == CH_UP_E);
    assign bdig    = bin_digit(ch);
    assign ddig    = dec_digit(ch);
    assign hdig    = hex_digit(ch);

    // Accumulator times the radix of the running digit form.
    always_comb
    begin
        unique case (run_base)
            ils_pkg::BASE_BIN: acc_scaled = {acc_reg[62:0], 1'b0};
            ils_pkg::BASE_OCT: acc_scaled = {acc_reg[60:0], 3'b000};
            ils_pkg::BASE_HEX: acc_scaled = {acc_reg[59:0], 4'b0000};
            default:           acc_scaled = {acc_reg[60:0], 3'b000}
                                          + {acc_reg[62:0], 1'b0};
        endcase
    end

    // Next scan state for the character in the input register.
    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        minus_next    = minus_reg;
        count_next    = count_reg;
        consumed_next = consumed_reg;
        done          = 1'b0;
        done_ok       = 1'b0;
        done_base     = ils_pkg::BASE_BIN;
        go_start      = 1'b0;
        run_active    = 1'b0;
        run_dig       = ddig;
        run_limit     = LIM_DEC;
        run_base      = ils_pkg::BASE_DEC;

        unique case (phase_reg)
            ils_pkg::PH_SIGNED:
            begin
                go_start = 1'b1;
            end
            ils_pkg::PH_ZERO:
            begin
                if (at_end)
                begin
                    done      = 1'b1;
                    done_ok   = 1'b1;
                    done_base = ils_pkg::BASE_DEC;
                end
                else if (ch == CH_LO_B)
                begin
                    phase_next = ils_pkg::PH_ZERO_B;
                end
                else if (ch == CH_LO_X)
                begin
                    phase_next = ils_pkg::PH_ZERO_X;
                end
                else if (ddig.ok)
                begin
                    acc_next      = {60'd0, ddig.val};
                    count_next    = CNT_ONE;
                    consumed_next = consumed_reg + 9'd1;
                    phase_next    = ils_pkg::PH_OCT;
                end
                else
                begin
                    done      = 1'b1;
                    done_ok   = !is_stop;
                    done_base = ils_pkg::BASE_DEC;
                end
            end
            ils_pkg::PH_ZERO_B:
            begin
                // A prefix letter without a digit falls back to decimal zero.
                if (at_end || !bdig.ok)
                begin
                    done      = 1'b1;
                    done_ok   = 1'b1;
                    done_base = ils_pkg::BASE_DEC;
                end
                else
                begin
                    acc_next      = {60'd0, bdig.val};
                    count_next    = CNT_ONE;
                    consumed_next = consumed_reg + 9'd2;
                    phase_next    = ils_pkg::PH_BIN;
                end
            end
            ils_pkg::PH_ZERO_X:
            begin
                if (at_end || !hdig.ok)
                begin
                    done      = 1'b1;
                    done_ok   = 1'b1;
                    done_base = ils_pkg::BASE_DEC;
                end
                else
                begin
                    acc_next      = {60'd0, hdig.val};
                    count_next    = CNT_ONE;
                    consumed_next = consumed_reg + 9'd2;
                    phase_next    = ils_pkg::PH_HEX;
                end
            end
            ils_pkg::PH_BIN:
            begin
                run_active = 1'b1;
                run_dig    = bdig;
                run_limit  = LIM_BIN;
                run_base   = ils_pkg::BASE_BIN;
            end
            ils_pkg::PH_OCT:
            begin
                run_active = 1'b1;
                run_dig    = ddig;
                run_limit  = LIM_OCT;
                run_base   = ils_pkg::BASE_OCT;
            end
            ils_pkg::PH_HEX:
            begin
                run_active = 1'b1;
                run_dig    = hdig;
                run_limit  = LIM_HEX;
                run_base   = ils_pkg::BASE_HEX;
            end
            ils_pkg::PH_DEC:
            begin
                run_active = 1'b1;
            end
            default:
            begin
                // Idle: an optional sign, then the first digit.
                if (at_end)
                begin
                    done = 1'b1;
                end
                else if ((ch == CH_PLUS) || (ch == CH_MINUS))
                begin
                    minus_next    = (ch == CH_MINUS);
                    consumed_next = 9'd1;
                    phase_next    = ils_pkg::PH_SIGNED;
                end
                else
                begin
                    go_start = 1'b1;
                end
            end
        endcase

        // First character of the digits after an optional sign.
        if (go_start)
        begin
            if (at_end)
            begin
                done = 1'b1;
            end
            else if (ch == CH_ZERO)
            begin
                consumed_next = consumed_reg + 9'd1;
                phase_next    = ils_pkg::PH_ZERO;
            end
            else if (ddig.ok)
            begin
                acc_next      = {60'd0, ddig.val};
                count_next    = CNT_ONE;
                consumed_next = consumed_reg + 9'd1;
                phase_next    = ils_pkg::PH_DEC;
            end
            else
            begin
                done = 1'b1;
            end
        end

        // Greedy digit run: take a digit below the limit, else check the follower.
        if (run_active)
        begin
            if (!at_end && run_dig.ok && (count_reg < run_limit))
            begin
                acc_next      = acc_scaled + {60'd0, run_dig.val};
                count_next    = count_reg + CNT_ONE;
                consumed_next = consumed_reg + 9'd1;
            end
            else
            begin
                done      = 1'b1;
                done_ok   = at_end || !is_stop;
                done_base = run_base;
            end
        end

        // A finished scan returns to idle with cleared state.
        if (done)
        begin
            phase_next    = ils_pkg::PH_IDLE;
            acc_next      = 64'd0;
            minus_next    = 1'b0;
            count_next    = '0;
            consumed_next = 9'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ils_pkg::PH_IDLE;
            acc_reg      <= 64'd0;
            minus_reg    <= 1'b0;
            count_reg    <= '0;
            consumed_reg <= 9'd0;
        end
        else if (step.fire)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            minus_reg    <= minus_next;
            count_reg    <= count_next;
            consumed_reg <= consumed_next;
        end
    end

    // Result word: a no-match carries all-zero fields.
    assign emit.valid          = step.fire && done;
    assign emit.word.matched   = done_ok;
    assign emit.word.negative  = done_ok && minus_reg;
    assign emit.word.base_code = done_ok ? done_base : ils_pkg::BASE_BIN;
    assign emit.word.magnitude = done_ok ? acc_reg : 64'd0;
    assign emit.word.length    = done_ok ? consumed_reg : 9'd0;

    `ILS_ASSERT_NEXT(a_done_to_idle, step.fire && done, phase_reg == ils_pkg::PH_IDLE, "scan did not return to idle after a result")
    `ILS_ASSERT_NOW(a_idle_clear, phase_reg == ils_pkg::PH_IDLE, (acc_reg == 64'd0) && (consumed_reg == 9'd0) && (count_reg == '0), "idle scanner holds stale state")
    `ILS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= LIM_TOP, "digit count beyond the largest limit")
    `ILS_ASSERT_NEXT(a_hold_idle, !step.fire, $stable(phase_reg) && $stable(acc_reg), "scan state moved without a character")

endmodule

/* hdl/ils_out_stage.sv */
module ils_out_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  ils_pkg::emit_t emit,
    output logic           res_free,
    output logic           res_valid,
    input  logic           res_stall,
    output ils_pkg::res_t  res_word
);

    logic          valid_reg;
    logic          valid_next;
    ils_pkg::res_t word_reg;

    // The register can take a new result when empty or when its word leaves now.
    assign res_free = !valid_reg || !res_stall;

    always_comb
    begin
        if (emit.valid)
        begin
            valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            word_reg <= emit.word;
        end
    end

    assign res_valid = valid_reg;
    assign res_word  = word_reg;

endmodule

/* hdl/integer_literal_scanner.sv */
// Integer literal scanner: feed text one character per word on the char channel
// (at_end marks end of text) and it reports each literal it scans on the res
// channel: an optional sign, then binary (0b), octal (leading 0), hex (0x) or
// decimal digits, with matched, sign, base, magnitude modulo 2^64 and length.
// The character that decides a literal is consumed by it and one result word
// follows; the scanner then starts over. Each character moves in a single step
// between the input register and the result register, so one word is accepted
// every cycle while the result side keeps up; a result word is registered when
// its deciding character leaves the input register to step the scanner.
module integer_literal_scanner
#(
    parameter int MAX_BIN_DIGITS = ils_pkg::DEF_MAX_BIN_DIGITS,
    parameter int MAX_OCT_DIGITS = ils_pkg::DEF_MAX_OCT_DIGITS,
    parameter int MAX_HEX_DIGITS = ils_pkg::DEF_MAX_HEX_DIGITS,
    parameter int MAX_DEC_DIGITS = ils_pkg::DEF_MAX_DEC_DIGITS
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           char_valid,
    output logic           char_stall,
    input  ils_pkg::char_t char_word,
    output logic           res_valid,
    input  logic           res_stall,
    output ils_pkg::res_t  res_word
);

    ils_pkg::step_t step;
    ils_pkg::emit_t emit;
    logic           res_free;

    ils_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .res_free   (res_free),
        .step       (step)
    );

    ils_core
    #(
        .MAX_BIN_DIGITS (MAX_BIN_DIGITS),
        .MAX_OCT_DIGITS (MAX_OCT_DIGITS),
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS),
        .MAX_DEC_DIGITS (MAX_DEC_DIGITS)
    )
    u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .emit  (emit)
    );

    ils_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule
